// ===== rtl/ordered_value_list_store_macros.svh =====
`ifndef ORDERED_VALUE_LIST_STORE_MACROS_SVH
`define ORDERED_VALUE_LIST_STORE_MACROS_SVH

// Both macros sample on the rising clock edge and stay quiet while reset is applied.
`define OVLS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list port check failed");

`define OVLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list port check failed");

`endif

// ===== rtl/ovls_pkg.sv =====
package ovls_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_DELETE,
        OP_SEARCH,
        OP_DUMP
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOTFOUND,
        ST_FULL,
        ST_EMPTY
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    idx_inc;
        logic    append_wr;
        logic    shift_wr;
        logic    count_inc;
        logic    count_dec;
        logic    emit;
        logic    emit_dump;
        status_t code;
    } ovls_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic hit;
        logic at_last;
        logic at_end;
        logic out_free;
    } ovls_stat_t;

endpackage

// ===== rtl/ovls_ctrl.sv =====
module ovls_ctrl
    import ovls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  ovls_stat_t stat,
    output ovls_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == OP_APPEND)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit = 1'b1;
                        if (stat.full)
                        begin
                            cmd.code = ST_FULL;
                        end
                        else
                        begin
                            cmd.append_wr = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_EMPTY;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.op == OP_DUMP)
                begin
                    state_next = S_DUMP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    if (stat.op == OP_DELETE)
                    begin
                        // Start closing the gap from the entry after the match.
                        cmd.idx_inc = 1'b1;
                        state_next  = S_SHIFT;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.at_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.at_end)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.count_dec = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.shift_wr = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_dump = 1'b1;
                    if (stat.at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ovls_dp.sv =====
module ovls_dp
    import ovls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] value,
    input  ovls_cmd_t                cmd,
    output ovls_stat_t               stat,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] item,
    output logic                     last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    op_t                      op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            idx_reg;
    logic [CW-1:0]            idx_next;
    logic [CW-1:0]            idx_prev;
    logic [CW-1:0]            idx_succ;

    logic                     out_valid_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] item_reg;
    logic                     last_reg;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    assign idx_succ = idx_reg + CW'(1);
    assign idx_prev = idx_reg - CW'(1);

    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_succ;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    // The read address follows the next index, so the read data always holds
    // the entry at the current index.
    assign wr_en   = cmd.append_wr | cmd.shift_wr;
    assign wr_addr = cmd.append_wr ? count_reg[AW-1:0] : idx_prev[AW-1:0];
    assign wr_data = cmd.append_wr ? value_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_next[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(op);
            value_reg <= value;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.code;
            item_reg   <= cmd.emit_dump ? rd_data_reg : '0;
            last_reg   <= cmd.emit_dump ? (idx_succ == count_reg) : 1'b1;
        end
    end

    assign stat.op       = op_reg;
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.hit      = (rd_data_reg == value_reg);
    assign stat.at_last  = (idx_succ == count_reg);
    assign stat.at_end   = (idx_reg == count_reg);
    assign stat.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign status    = status_reg;
    assign item      = item_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/ordered_value_list_store.sv =====
// Append, and any request on an empty list, is answered from the dispatch state; search
// and delete walk the list one entry a cycle, and delete then closes the gap it leaves.
// Dump gives one result per cycle while its results are taken.
// One transaction is in work at a time: the next request is taken only once the result
// of the last one has been issued; a stalled result delays both the next result and request.
// Reset clears the entry count and the control state; entry storage needs no clearing.
module ordered_value_list_store
    import ovls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] item,
    output logic                     last
);

    ovls_cmd_t  cmd;
    ovls_stat_t stat;

    ovls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ovls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .item      (item),
        .last      (last)
    );

endmodule

// ===== rtl/ovls_checker.sv =====
`include "ordered_value_list_store_macros.svh"

module ovls_props
    import ovls_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic [1:0]               op,
    input logic signed [DATA_W-1:0] value,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [1:0]               status,
    input logic signed [DATA_W-1:0] item,
    input logic                     last
);

    // A stalled result keeps its payload.
    `OVLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(item) && $stable(last))

    // Only a dump produces more than one result, and dump results are all successes.
    `OVLS_ASSERT_SAME(a_multi_is_dump, rsp_valid && !last, status == ST_OK)

    // Failure results never carry an entry value.
    `OVLS_ASSERT_SAME(a_fail_item_zero, rsp_valid && status != ST_OK, item == '0)

    // An accepted request is worked on alone; the block is busy the next cycle.
    `OVLS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

endmodule

bind ordered_value_list_store ovls_props u_ovls_checker (.*);
